// File: rtl/core/box_filter_3x3_replicate_core_assert.svh
`ifndef BOX_FILTER_3X3_REPLICATE_CORE_ASSERT_SVH
`define BOX_FILTER_3X3_REPLICATE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BF3R_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BF3R_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bf3r_pkg.sv
package bf3r_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int PixW   = 8;
  localparam int CoordW = 10;
  localparam int CfgW   = 11;

  localparam int AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int ColW  = ($clog2(MaxWidth) > CoordW) ? $clog2(MaxWidth) : CoordW;
  localparam int RowW  = ($clog2(MaxHeight) > CoordW) ? $clog2(MaxHeight) : CoordW;
  localparam int DimW0 = (ColW > RowW) ? ColW + 1 : RowW + 1;
  localparam int DimW  = (DimW0 > CfgW) ? DimW0 : CfgW;

  localparam int ColSumW = $clog2(3 * ((1 << PixW) - 1) + 1);
  localparam int SumW    = $clog2(9 * ((1 << PixW) - 1) + 1);

  // x / 9 == (x * 3641) >> 15 for every 3x3 sum of 8-bit pixels
  localparam int RecipMul   = 3641;
  localparam int RecipW     = 12;
  localparam int RecipShift = 15;

  localparam logic [CfgW-1:0] WidthReset  = CfgW'(768);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(512);

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  // result slots of one item, in output order
  localparam int NumSlots = 4;
  localparam int SlotW    = 2;
  localparam logic [SlotW-1:0] SlotAbovePrev = 2'd0;
  localparam logic [SlotW-1:0] SlotLastPrev  = 2'd1;
  localparam logic [SlotW-1:0] SlotAboveCur  = 2'd2;
  localparam logic [SlotW-1:0] SlotLastCur   = 2'd3;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
  } pos_flags_t;

  typedef struct packed {
    logic [NumSlots-1:0]           mask;
    logic [NumSlots-1:0][SumW-1:0] total;
    logic [RowW-1:0]               row;
    logic [ColW-1:0]               col;
  } run_t;

endpackage

// File: rtl/core/bf3r_line_store.sv
module bf3r_line_store (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [bf3r_pkg::AddrW-1:0]   rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [bf3r_pkg::AddrW-1:0]   wr_addr_i,
  input  logic [bf3r_pkg::PixW-1:0]    wr_upper_i,
  input  logic [bf3r_pkg::PixW-1:0]    wr_lower_i,
  output logic [bf3r_pkg::PixW-1:0]    upper_o,
  output logic [bf3r_pkg::PixW-1:0]    lower_o
);
  import bf3r_pkg::*;

  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] lower_mem [MaxWidth];
  logic [PixW-1:0] upper_q;
  logic [PixW-1:0] lower_q;
  logic            fwd;

  // a one-pixel-wide frame reads the entry that is being written
  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= wr_upper_i;
      lower_mem[wr_addr_i] <= wr_lower_i;
    end
    if (rd_en_i) begin
      upper_q <= fwd ? wr_upper_i : upper_mem[rd_addr_i];
      lower_q <= fwd ? wr_lower_i : lower_mem[rd_addr_i];
    end
  end

  assign upper_o = upper_q;
  assign lower_o = lower_q;

endmodule

// File: rtl/core/bf3r_window.sv
module bf3r_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  bf3r_pkg::pos_flags_t        flags_i,
  input  logic [bf3r_pkg::PixW-1:0]   pix_i,
  input  logic [bf3r_pkg::PixW-1:0]   upper_i,
  input  logic [bf3r_pkg::PixW-1:0]   lower_i,
  input  logic [bf3r_pkg::RowW-1:0]   row_i,
  input  logic [bf3r_pkg::ColW-1:0]   col_i,
  output bf3r_pkg::run_t              run_o
);
  import bf3r_pkg::*;

  // [column][row], column 2 newest, row 2 current
  logic [2:0][2:0][PixW-1:0] win_q, win_d;
  logic [2:0][PixW-1:0]      new_col;
  logic [PixW-1:0]           pix_b, pix_a;
  logic [2:0][ColSumW-1:0]   full_sum, bot_sum;

  always_comb begin
    pix_b = flags_i.row_ge1 ? lower_i : pix_i;
    pix_a = flags_i.row_ge2 ? upper_i : pix_b;
    new_col[0] = pix_a;
    new_col[1] = pix_b;
    new_col[2] = pix_i;
    if (flags_i.first_col) begin
      win_d[0] = new_col;
      win_d[1] = new_col;
      win_d[2] = new_col;
    end else begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = new_col;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_sum[i] = ColSumW'(win_d[i][0]) + ColSumW'(win_d[i][1]) + ColSumW'(win_d[i][2]);
      bot_sum[i]  = ColSumW'(win_d[i][1]) + (ColSumW'(win_d[i][2]) << 1);
    end
  end

  always_comb begin
    run_o.total[SlotAbovePrev] = SumW'(full_sum[0]) + SumW'(full_sum[1]) + SumW'(full_sum[2]);
    run_o.total[SlotLastPrev]  = SumW'(bot_sum[0]) + SumW'(bot_sum[1]) + SumW'(bot_sum[2]);
    run_o.total[SlotAboveCur]  = SumW'(full_sum[1]) + (SumW'(full_sum[2]) << 1);
    run_o.total[SlotLastCur]   = SumW'(bot_sum[1]) + (SumW'(bot_sum[2]) << 1);
    run_o.mask[SlotAbovePrev]  = !flags_i.first_col && flags_i.row_ge1;
    run_o.mask[SlotLastPrev]   = !flags_i.first_col && flags_i.last_row;
    run_o.mask[SlotAboveCur]   = flags_i.last_col && flags_i.row_ge1;
    run_o.mask[SlotLastCur]    = flags_i.last_col && flags_i.last_row;
    run_o.row = row_i;
    run_o.col = col_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv_i) begin
      win_q <= win_d;
    end
  end

endmodule

// File: rtl/core/bf3r_out_seq.sv
module bf3r_out_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  bf3r_pkg::run_t               run_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bf3r_pkg::PixW-1:0]    filtered_pixel_o,
  output logic [bf3r_pkg::CoordW-1:0]  out_row_o,
  output logic [bf3r_pkg::CoordW-1:0]  out_col_o,
  output logic                         end_of_frame_o,
  output logic                         last_in_run_o
);
  import bf3r_pkg::*;

  logic                          run_valid_q;
  run_t                          run_q;
  logic [SlotW-1:0]              idx;
  logic [NumSlots-1:0]           rest;
  logic                          last;
  logic                          out_ready;
  logic                          emit;
  logic [SumW-1:0]               sel_total;
  logic [SumW+RecipW-1:0]        prod;
  logic                          above, prev;
  logic [RowW-1:0]               res_row;
  logic [ColW-1:0]               res_col;

  logic                          out_valid_q;
  logic [PixW-1:0]               pix_q;
  logic [CoordW-1:0]             row_q, col_q;
  logic                          eof_q, last_q;

  always_comb begin
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (run_q.mask[i]) begin
        idx = SlotW'(i);
      end
    end
    rest = run_q.mask;
    rest[idx] = 1'b0;
    last = (rest == '0);
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = run_valid_q && out_ready;
  assign free_o    = !run_valid_q || (emit && last);

  assign sel_total = run_q.total[idx];
  assign prod      = (SumW + RecipW)'(sel_total) * (SumW + RecipW)'(RecipMul);
  assign above     = (idx == SlotAbovePrev) || (idx == SlotAboveCur);
  assign prev      = (idx == SlotAbovePrev) || (idx == SlotLastPrev);
  assign res_row   = above ? run_q.row - RowW'(1) : run_q.row;
  assign res_col   = prev ? run_q.col - ColW'(1) : run_q.col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        run_valid_q <= 1'b1;
      end else if (emit && last) begin
        run_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end else if (emit) begin
      run_q.mask <= rest;
    end
    if (emit) begin
      pix_q  <= prod[RecipShift +: PixW];
      row_q  <= res_row[CoordW-1:0];
      col_q  <= res_col[CoordW-1:0];
      eof_q  <= (idx == SlotLastCur);
      last_q <= last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_pixel_o = pix_q;
  assign out_row_o        = row_q;
  assign out_col_o        = col_q;
  assign end_of_frame_o   = eof_q;
  assign last_in_run_o    = last_q;

endmodule

// File: rtl/core/box_filter_3x3_replicate_core.sv
// 3x3 box filter with replicated borders over a raster-order 8-bit pixel stream.
// Frame size is set through frame_width (index 0) and frame_height (index 1), each
// taken as 1..1024; write them only while no item is in flight. Each result is the
// neighborhood sum divided by nine, truncated, tagged with its row and column; a
// result leaves once its lower-right neighbor has arrived, and on the last row the
// results of the last two rows come out interleaved. Input items are taken one per
// clock as long as each causes at most one result and the output is not stalled; an
// item at the right edge or on the last row causes up to four, and since the output
// register hands out one result per clock when not stalled, such an item stalls the
// input until its further results are out. An item's first result passes the input
// stage, run and output registers. The two line stores, single-port-write memories,
// are read on accept, written on input-stage exit and need no clearing after reset.
`include "box_filter_3x3_replicate_core_assert.svh"

module box_filter_3x3_replicate_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  bf3r_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [bf3r_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bf3r_pkg::PixW-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bf3r_pkg::PixW-1:0]     filtered_pixel_o,
  output logic [bf3r_pkg::CoordW-1:0]   out_row_o,
  output logic [bf3r_pkg::CoordW-1:0]   out_col_o,
  output logic                          end_of_frame_o,
  output logic                          last_in_run_o
);
  import bf3r_pkg::*;

  logic [CfgW-1:0]  frame_width_q, frame_height_q;
  logic [DimW-1:0]  width_ext, height_ext, w_eff, h_eff;

  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic             restart;
  logic [RowW-1:0]  acc_row;
  logic [ColW-1:0]  acc_col;
  pos_flags_t       acc_flags;
  logic             in_acc;

  logic             s1_valid_q;
  logic [PixW-1:0]  s1_pix_q;
  logic [RowW-1:0]  s1_row_q;
  logic [ColW-1:0]  s1_col_q;
  pos_flags_t       s1_flags_q;
  logic             s1_adv;

  logic [PixW-1:0]  upper_rd, lower_rd;
  run_t             run;
  logic             run_free;
  logic             run_load;

  // effective frame dimensions
  always_comb begin
    width_ext  = DimW'(frame_width_q);
    height_ext = DimW'(frame_height_q);
    if (width_ext == '0) begin
      w_eff = DimW'(1);
    end else if (width_ext > DimW'(MaxWidth)) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = width_ext;
    end
    if (height_ext == '0) begin
      h_eff = DimW'(1);
    end else if (height_ext > DimW'(MaxHeight)) begin
      h_eff = DimW'(MaxHeight);
    end else begin
      h_eff = height_ext;
    end
  end

  always_comb begin
    restart = (DimW'(col_q) >= w_eff) || (DimW'(row_q) >= h_eff);
    acc_row = restart ? '0 : row_q;
    acc_col = restart ? '0 : col_q;
    acc_flags.first_col = (acc_col == '0);
    acc_flags.last_col  = (DimW'(acc_col) == w_eff - DimW'(1));
    acc_flags.row_ge1   = (acc_row != '0);
    acc_flags.row_ge2   = (acc_row > RowW'(1));
    acc_flags.last_row  = (DimW'(acc_row) == h_eff - DimW'(1));
  end

  assign in_stall_o = s1_valid_q && !run_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_valid_q && run_free;
  assign run_load   = s1_adv && (run.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthReset;
      frame_height_q <= HeightReset;
      row_q          <= '0;
      col_q          <= '0;
      s1_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFrameWidth:  frame_width_q  <= cfg_wdata_i;
          CfgFrameHeight: frame_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (acc_flags.last_col) begin
          col_q <= '0;
          row_q <= acc_flags.last_row ? '0 : acc_row + RowW'(1);
        end else begin
          col_q <= acc_col + ColW'(1);
          row_q <= acc_row;
        end
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= pixel_in_i;
      s1_row_q   <= acc_row;
      s1_col_q   <= acc_col;
      s1_flags_q <= acc_flags;
    end
  end

  bf3r_line_store u_line_store (
    .clk_i      (clk_i),
    .rd_en_i    (in_acc),
    .rd_addr_i  (acc_col[AddrW-1:0]),
    .wr_en_i    (s1_adv),
    .wr_addr_i  (s1_col_q[AddrW-1:0]),
    .wr_upper_i (lower_rd),
    .wr_lower_i (s1_pix_q),
    .upper_o    (upper_rd),
    .lower_o    (lower_rd)
  );

  bf3r_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .flags_i (s1_flags_q),
    .pix_i   (s1_pix_q),
    .upper_i (upper_rd),
    .lower_i (lower_rd),
    .row_i   (s1_row_q),
    .col_i   (s1_col_q),
    .run_o   (run)
  );

  bf3r_out_seq u_out_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (run_load),
    .run_i            (run),
    .free_o           (run_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_pixel_o (filtered_pixel_o),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o),
    .end_of_frame_o   (end_of_frame_o),
    .last_in_run_o    (last_in_run_o)
  );

  `BF3R_ASSERT_NOW(a_eof_ends_run, out_valid_o && end_of_frame_o, last_in_run_o, "end of frame not last in run")
  `BF3R_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q, "input stalled with empty stage")
  `BF3R_ASSERT_NEXT(a_frame_wrap, in_acc && acc_flags.last_col && acc_flags.last_row, (row_q == '0) && (col_q == '0), "position did not wrap at frame end")

endmodule
